// ===== rtl/rrc_pkg.sv =====
// Shared constants, codes, payload and control types of the rectangle raster canvas.
// No dependencies; every other file refers to it by scoped names.
package rrc_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 8;

  localparam int COORD_W = 21;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int DIM_W   = 10;
  localparam int CHAR_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  // coordinate sums and walk positions scaled to fixed point share this width
  localparam int XW = COORD_W + 3;

  localparam logic signed [XW-1:0] UNIT = XW'(2 ** FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_DRAW  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } rrc_mode_e;

  localparam logic [1:0] KIND_FILL    = 2'd0;
  localparam logic [1:0] KIND_OUTLINE = 2'd1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

  localparam logic [DIM_W-1:0]  RST_CANVAS_WIDTH  = 10'd1;
  localparam logic [DIM_W-1:0]  RST_CANVAS_HEIGHT = 10'd1;
  localparam logic [CHAR_W-1:0] RST_BACKGROUND    = 8'd32;

  typedef struct packed {
    logic [1:0]                mode;
    logic [1:0]                shape_kind;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_width;
    logic signed [COORD_W-1:0] rect_height;
    logic [CHAR_W-1:0]         paint_char;
    logic [COL_W-1:0]          pixel_col;
    logic [ROW_W-1:0]          pixel_row;
  } rrc_cmd_t;

  // controller to datapath
  typedef struct packed {
    logic cmd_load;
    logic walk_en;
    logic mem_rd;
    logic res_load;
  } rrc_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       draw_invalid;
    logic       read_outside;
    logic       canvas_empty;
    logic       walk_last;
  } rrc_sts_t;

  function automatic logic signed [XW-1:0] ext_coord(logic signed [COORD_W-1:0] v);
    return XW'(v);
  endfunction

  function automatic logic signed [XW-1:0] scale_col(logic [COL_W-1:0] c);
    return $signed(XW'(c) << FRAC_BITS);
  endfunction

  function automatic logic signed [XW-1:0] scale_row(logic [ROW_W-1:0] r);
    return $signed(XW'(r) << FRAC_BITS);
  endfunction

endpackage

// ===== rtl/rrc_if.sv =====
// Channel interfaces of the rectangle raster canvas: command, result and register write.
// Depends on rrc_pkg for field widths.
interface rrc_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic [1:0]                         shape_kind;
  logic signed [rrc_pkg::COORD_W-1:0] rect_left;
  logic signed [rrc_pkg::COORD_W-1:0] rect_top;
  logic signed [rrc_pkg::COORD_W-1:0] rect_width;
  logic signed [rrc_pkg::COORD_W-1:0] rect_height;
  logic [rrc_pkg::CHAR_W-1:0]         paint_char;
  logic [rrc_pkg::COL_W-1:0]          pixel_col;
  logic [rrc_pkg::ROW_W-1:0]          pixel_row;

  modport source (output valid, mode, shape_kind, rect_left, rect_top, rect_width,
                  rect_height, paint_char, pixel_col, pixel_row, input ready);
  modport sink   (input valid, mode, shape_kind, rect_left, rect_top, rect_width,
                  rect_height, paint_char, pixel_col, pixel_row, output ready);
endinterface

interface rrc_res_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [rrc_pkg::CHAR_W-1:0] pixel_value;

  modport source (output valid, status, pixel_value, input ready);
  modport sink   (input valid, status, pixel_value, output ready);
endinterface

interface rrc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrc_pkg::CFG_IDX_W-1:0]  index;
  logic [rrc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rrc_datapath.sv =====
// Datapath: configuration registers, command registers, scan counters, canvas memory
// and result register. Depends on rrc_pkg.
module rrc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rrc_pkg::rrc_cmd_t              cmd_i,
  input  logic                           cfg_we_i,
  input  logic [rrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rrc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  rrc_pkg::rrc_ctl_t              ctl_i,
  output rrc_pkg::rrc_sts_t              sts_o,
  output logic [1:0]                     res_status_o,
  output logic [rrc_pkg::CHAR_W-1:0]     res_value_o
);

  logic [rrc_pkg::DIM_W-1:0]  width_q, height_q;
  logic [rrc_pkg::CHAR_W-1:0] bg_q;
  logic [rrc_pkg::COL_W-1:0]  walk_col_q;
  logic [rrc_pkg::ROW_W-1:0]  walk_row_q;

  logic [1:0]                 mode_q, kind_q;
  logic                       invalid_q;
  logic [rrc_pkg::CHAR_W-1:0] paint_q;
  logic [rrc_pkg::COL_W-1:0]  col_q;
  logic [rrc_pkg::ROW_W-1:0]  row_q;
  logic signed [rrc_pkg::XW-1:0] left_q, right_q, top_q, bottom_q;
  logic signed [rrc_pkg::XW-1:0] left1_q, right1_q, top1_q, bottom1_q;

  logic [rrc_pkg::CHAR_W-1:0] canvas_mem [2**rrc_pkg::ADDR_W];
  logic [rrc_pkg::CHAR_W-1:0] rd_data_q;
  logic [1:0]                 res_status_q;
  logic [rrc_pkg::CHAR_W-1:0] res_value_q;

  logic [rrc_pkg::DIM_W-1:0]  cols, rows;
  logic                       col_last, row_last;
  logic signed [rrc_pkg::XW-1:0] px, py, in_left, in_top, in_right, in_bottom;
  logic                       in_rect, edge_hit, hit, mem_we, outside;
  logic [rrc_pkg::CHAR_W-1:0] wr_data;
  logic [1:0]                 status_d;
  logic [rrc_pkg::CHAR_W-1:0] value_d;

  // saturate the canvas size to the memory dimensions
  assign cols = (width_q > rrc_pkg::DIM_W'(rrc_pkg::MAX_WIDTH))
              ? rrc_pkg::DIM_W'(rrc_pkg::MAX_WIDTH) : width_q;
  assign rows = (height_q > rrc_pkg::DIM_W'(rrc_pkg::MAX_HEIGHT))
              ? rrc_pkg::DIM_W'(rrc_pkg::MAX_HEIGHT) : height_q;

  assign col_last = ({1'b0, walk_col_q} == cols - 1'b1);
  assign row_last = ({1'b0, walk_row_q} == rows - 1'b1);
  assign outside  = ({1'b0, col_q} >= cols) || ({1'b0, row_q} >= rows);

  assign sts_o.mode         = mode_q;
  assign sts_o.draw_invalid = invalid_q;
  assign sts_o.read_outside = outside;
  assign sts_o.canvas_empty = (cols == '0) || (rows == '0);
  assign sts_o.walk_last    = col_last && row_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rrc_pkg::RST_CANVAS_WIDTH;
      height_q <= rrc_pkg::RST_CANVAS_HEIGHT;
      bg_q     <= rrc_pkg::RST_BACKGROUND;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rrc_pkg::CFG_CANVAS_WIDTH:  width_q  <= cfg_data_i;
        rrc_pkg::CFG_CANVAS_HEIGHT: height_q <= cfg_data_i;
        rrc_pkg::CFG_BACKGROUND:    bg_q     <= cfg_data_i[rrc_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // scan position; wraps back to the origin after the last pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_col_q <= '0;
      walk_row_q <= '0;
    end else if (ctl_i.walk_en) begin
      if (col_last) begin
        walk_col_q <= '0;
        walk_row_q <= row_last ? '0 : walk_row_q + 1'b1;
      end else begin
        walk_col_q <= walk_col_q + 1'b1;
      end
    end
  end

  assign in_left   = rrc_pkg::ext_coord(cmd_i.rect_left);
  assign in_top    = rrc_pkg::ext_coord(cmd_i.rect_top);
  assign in_right  = in_left + rrc_pkg::ext_coord(cmd_i.rect_width);
  assign in_bottom = in_top + rrc_pkg::ext_coord(cmd_i.rect_height);

  // latch the command and the rectangle bounds in fixed point
  always_ff @(posedge clk_i) begin
    if (ctl_i.cmd_load) begin
      mode_q    <= cmd_i.mode;
      kind_q    <= cmd_i.shape_kind;
      paint_q   <= cmd_i.paint_char;
      col_q     <= cmd_i.pixel_col;
      row_q     <= cmd_i.pixel_row;
      invalid_q <= (cmd_i.rect_width <= 0) || (cmd_i.rect_height <= 0)
                || (cmd_i.shape_kind != rrc_pkg::KIND_FILL
                    && cmd_i.shape_kind != rrc_pkg::KIND_OUTLINE);
      left_q    <= in_left;
      top_q     <= in_top;
      right_q   <= in_right;
      bottom_q  <= in_bottom;
      left1_q   <= in_left + rrc_pkg::UNIT;
      top1_q    <= in_top + rrc_pkg::UNIT;
      right1_q  <= in_right - rrc_pkg::UNIT;
      bottom1_q <= in_bottom - rrc_pkg::UNIT;
    end
  end

  assign px = rrc_pkg::scale_col(walk_col_q);
  assign py = rrc_pkg::scale_row(walk_row_q);

  assign in_rect  = (left_q <= px) && (px <= right_q) && (top_q <= py) && (py <= bottom_q);
  assign edge_hit = (px < left1_q) || (right1_q < px) || (py < top1_q) || (bottom1_q < py);
  assign hit      = in_rect && ((kind_q == rrc_pkg::KIND_FILL) || edge_hit);

  assign mem_we  = ctl_i.walk_en && ((mode_q == rrc_pkg::MODE_CLEAR) || hit);
  assign wr_data = (mode_q == rrc_pkg::MODE_CLEAR) ? bg_q : paint_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      canvas_mem[{walk_row_q, walk_col_q}] <= wr_data;
    end
    if (ctl_i.mem_rd) begin
      rd_data_q <= canvas_mem[{row_q, col_q}];
    end
  end

  always_comb begin
    status_d = rrc_pkg::STATUS_OK;
    value_d  = '0;
    unique case (rrc_pkg::rrc_mode_e'(mode_q))
      rrc_pkg::MODE_DRAW: begin
        if (invalid_q) status_d = rrc_pkg::STATUS_INVALID;
      end
      rrc_pkg::MODE_READ: begin
        if (outside) status_d = rrc_pkg::STATUS_OUTSIDE;
        else         value_d  = rd_data_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      res_status_q <= status_d;
      res_value_q  <= value_d;
    end
  end

  assign res_status_o = res_status_q;
  assign res_value_o  = res_value_q;

endmodule

// ===== rtl/rrc_ctrl.sv =====
// Controller: sequences decode, canvas scan, pixel read and result hand-off.
// Depends on rrc_pkg; drives the datapath through rrc_ctl_t.
module rrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  input  rrc_pkg::rrc_sts_t sts_i,
  output rrc_pkg::rrc_ctl_t ctl_o
);

  typedef enum logic [2:0] {
    IDLE,
    DECODE,
    WALK,
    READ,
    FINISH
  } state_e;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;
  logic   slot_free;

  assign slot_free  = !res_valid_q || res_ready_i;
  assign in_ready_o = (state_q == IDLE);
  assign res_valid_o = res_valid_q;

  assign ctl_o.cmd_load = in_valid_i && in_ready_o;
  assign ctl_o.walk_en  = (state_q == WALK);
  assign ctl_o.mem_rd   = (state_q == READ);
  assign ctl_o.res_load = (state_q == FINISH) && slot_free;

  always_comb begin
    state_d     = state_q;
    res_valid_d = res_valid_q && !res_ready_i;
    unique case (state_q)
      IDLE: begin
        if (in_valid_i) state_d = DECODE;
      end
      DECODE: begin
        unique case (rrc_pkg::rrc_mode_e'(sts_i.mode))
          rrc_pkg::MODE_CLEAR: state_d = sts_i.canvas_empty ? FINISH : WALK;
          rrc_pkg::MODE_DRAW:
            state_d = (sts_i.draw_invalid || sts_i.canvas_empty) ? FINISH : WALK;
          rrc_pkg::MODE_READ:  state_d = sts_i.read_outside ? FINISH : READ;
          rrc_pkg::MODE_NONE:  state_d = FINISH;
        endcase
      end
      WALK: begin
        if (sts_i.walk_last) state_d = FINISH;
      end
      READ: state_d = FINISH;
      FINISH: begin
        // hold until the result register is free
        if (slot_free) begin
          res_valid_d = 1'b1;
          state_d     = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.res_load |-> (!res_valid_q || res_ready_i))
    else $error("result register overwritten while a transaction is pending");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == DECODE))
    else $error("accepted command not decoded");

  a_walk_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == WALK && !sts_i.walk_last) |=> (state_q == WALK))
    else $error("canvas scan left before its last pixel");

  a_read_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == READ) |=> (state_q == FINISH))
    else $error("pixel read not followed by result");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FINISH && slot_free) |=> (res_valid_q && state_q == IDLE))
    else $error("finished command produced no result");

endmodule

// ===== rtl/rectangle_raster_canvas.sv =====
// Top level of the rectangle raster canvas: joins controller and datapath to the channels.
// Depends on rrc_pkg, rrc_if, rrc_ctrl and rrc_datapath.
//
//  channel | role   | payload                                           | transaction
//  cmd_i   | sink   | mode, shape_kind, rect_*, paint_char, pixel_col/row | valid & ready
//  res_o   | source | status, pixel_value                               | valid & ready
//  cfg_i   | sink   | index (0 width, 1 height, 2 background), data     | valid & ready
//
// Clear and draw scan the canvas in WALK, one pixel per cycle through the single write
// port of the canvas memory. Reads pass DECODE, READ and FINISH; rejected commands go
// from DECODE to FINISH. One command is in flight at a time; the next is taken as soon as
// the result sits in the output register, even while that result is not yet taken.
// Reset clears the controller state, scan position and configuration registers only;
// canvas contents are undefined until a clear. cfg_i is always ready.
module rectangle_raster_canvas (
  input  logic  clk_i,
  input  logic  rst_ni,
  rrc_cmd_if.sink   cmd_i,
  rrc_res_if.source res_o,
  rrc_cfg_if.sink   cfg_i
);

  rrc_pkg::rrc_cmd_t cmd;
  rrc_pkg::rrc_ctl_t ctl;
  rrc_pkg::rrc_sts_t sts;

  assign cmd.mode        = cmd_i.mode;
  assign cmd.shape_kind  = cmd_i.shape_kind;
  assign cmd.rect_left   = cmd_i.rect_left;
  assign cmd.rect_top    = cmd_i.rect_top;
  assign cmd.rect_width  = cmd_i.rect_width;
  assign cmd.rect_height = cmd_i.rect_height;
  assign cmd.paint_char  = cmd_i.paint_char;
  assign cmd.pixel_col   = cmd_i.pixel_col;
  assign cmd.pixel_row   = cmd_i.pixel_row;

  assign cfg_i.ready = 1'b1;

  rrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  rrc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .res_status_o (res_o.status),
    .res_value_o  (res_o.pixel_value)
  );

endmodule
